>>> src/ngate_pkg.sv
// shared constants, codes and payload types of the noise gate
// no dependencies; used by every module of the block but ngate_ram, by scoped names
`default_nettype none

package ngate_pkg;

    localparam int CHANNELS      = 8;
    localparam int SAMPLE_BITS   = 24;
    localparam int CH_BITS       = 3;
    localparam int TIME_BITS     = 32;
    localparam int LEN_BITS      = 24;
    localparam int GAIN_BITS     = 16;
    localparam int PH_BITS       = 3;
    localparam int CFG_IDX_BITS  = 4;
    localparam int CFG_DATA_BITS = 24;

    // state memory address width
    localparam int CH_AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam logic [CH_BITS:0] CH_COUNT = (CH_BITS + 1)'(CHANNELS);

    // gain of exactly one in Q1.16
    localparam logic [GAIN_BITS:0] GAIN_ONE = {1'b1, {GAIN_BITS{1'b0}}};

    // gate phases
    localparam logic [PH_BITS-1:0] PH_CLOSED  = 3'd0;
    localparam logic [PH_BITS-1:0] PH_ATTACK  = 3'd1;
    localparam logic [PH_BITS-1:0] PH_OPEN    = 3'd2;
    localparam logic [PH_BITS-1:0] PH_HOLD    = 3'd3;
    localparam logic [PH_BITS-1:0] PH_RELEASE = 3'd4;

    // configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_THRESHOLD = 4'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_ATTACK    = 4'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_HOLD      = 4'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_RELEASE   = 4'd3;

    typedef struct packed {
        logic [CH_BITS-1:0]            chan;
        logic signed [SAMPLE_BITS-1:0] in_sample;
        logic [TIME_BITS-1:0]          frame_time;
    } t_in;

    typedef struct packed {
        logic [CH_BITS-1:0]            out_chan;
        logic signed [SAMPLE_BITS-1:0] out_sample;
        logic [PH_BITS-1:0]            gate_phase;
    } t_out;

    // one channel's entry in the state memory
    typedef struct packed {
        logic [PH_BITS-1:0]   phase;
        logic [TIME_BITS-1:0] start;
    } t_entry;

    localparam int ENTRY_BITS = $bits(t_entry);

endpackage

`default_nettype wire

>>> src/ngate_ram.sv
// generic single-port-write, single-port-read ram with registered read
// no dependencies
`default_nettype none

module ngate_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  wire logic                                    i_clk,
    input  wire logic                                    i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                        i_wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

>>> src/ngate_div.sv
// restoring divider for the ramp gain: floor(num * 2^16 / den), num < den
// depends on ngate_pkg for widths
`default_nettype none

module ngate_div (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_start,
    input  wire logic [ngate_pkg::LEN_BITS-1:0] i_num,
    input  wire logic [ngate_pkg::LEN_BITS-1:0] i_den,
    output logic                                o_done,
    output logic [ngate_pkg::GAIN_BITS-1:0]     o_quot
);

    localparam int CW = $clog2(ngate_pkg::GAIN_BITS + 1);

    logic                             r_busy;
    logic [CW-1:0]                    r_cnt;
    logic [ngate_pkg::LEN_BITS-1:0]   r_rem;
    logic [ngate_pkg::LEN_BITS-1:0]   r_den;
    logic [ngate_pkg::LEN_BITS:0]     shifted;
    logic [ngate_pkg::LEN_BITS:0]     diff;
    logic                             fits;

    // remainder stays below the divisor, so one doubling fits one extra bit
    assign shifted = {r_rem, 1'b0};
    assign diff    = shifted - {1'b0, r_den};
    assign fits    = shifted >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(ngate_pkg::GAIN_BITS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= i_num;
            r_den  <= i_den;
            o_quot <= '0;
        end else if (r_busy) begin
            r_rem  <= fits ? diff[ngate_pkg::LEN_BITS-1:0]
                           : shifted[ngate_pkg::LEN_BITS-1:0];
            o_quot <= {o_quot[ngate_pkg::GAIN_BITS-2:0], fits};
        end
    end

endmodule

`default_nettype wire

>>> src/noise_gate_attack_hold_release.sv
// top level of the per-channel noise gate with attack, hold and release
// depends on ngate_pkg, ngate_ram (channel state) and ngate_div (ramp gain)
`default_nettype none

// Per-channel noise gate. Each input transfer carries a channel number, a signed
// Q1.23 sample and a frame timestamp in sample periods; each one yields exactly one
// output transfer with the gated sample and the channel's phase after the sample
// (closed, attack, open, hold, release). Phase and phase start time of every
// channel live in a small state memory looked up in the cycle after the input
// transfer and written back when the result enters the output register; entries
// read as open with start time zero after reset until first written. Items are
// handled one at a time: a sample that needs no ramp gain goes from the lookup
// state straight to the output state, a sample in an attack or release ramp first
// passes the 16-step restoring divider that forms elapsed/ramp length and a rescale.
// The next input transfer is taken as soon as the result sits in the output
// register, even while that result still waits downstream. Configuration writes
// (threshold, attack, hold, release time) are always accepted and belong in
// quiet periods between items; writes to unknown indexes are dropped. A channel
// number at or above the channel count passes the sample through as open.
module noise_gate_attack_hold_release (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // sample input
    input  wire logic                                i_in_valid,
    output logic                                     o_in_ready,
    input  wire ngate_pkg::t_in                      i_in,
    // gated output
    output logic                                     o_out_valid,
    input  wire logic                                i_out_ready,
    output ngate_pkg::t_out                          o_out,
    // configuration writes
    input  wire logic                                i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  wire logic [ngate_pkg::CFG_IDX_BITS-1:0]  i_cfg_index,
    input  wire logic [ngate_pkg::CFG_DATA_BITS-1:0] i_cfg_data
);

    localparam int SB = ngate_pkg::SAMPLE_BITS;
    localparam int GB = ngate_pkg::GAIN_BITS;
    localparam int PB = SB + GB + 1;

    // sequencer states
    localparam logic [2:0] S_IDLE = 3'd0;   // waiting for an input transfer
    localparam logic [2:0] S_LOOK = 3'd1;   // state entry arrives, decide
    localparam logic [2:0] S_DIV  = 3'd2;   // gain division running
    localparam logic [2:0] S_MUL  = 3'd3;   // product registered, rescale
    localparam logic [2:0] S_OUT  = 3'd4;   // load output register, write back

    logic [2:0] r_state;

    // configuration registers
    logic signed [SB-1:0]                 r_thr;
    logic [ngate_pkg::LEN_BITS-1:0]       r_att;
    logic [ngate_pkg::LEN_BITS-1:0]       r_hold;
    logic [ngate_pkg::LEN_BITS-1:0]       r_rel;

    // item in flight
    ngate_pkg::t_in                       r_in;
    logic [ngate_pkg::PH_BITS-1:0]        r_ph;
    logic [ngate_pkg::TIME_BITS-1:0]      r_start;
    logic                                 r_rel_ramp;
    logic                                 r_neg;
    logic [SB-1:0]                        r_mag;
    logic [PB-1:0]                        r_prod;
    logic signed [SB-1:0]                 r_y;
    logic                                 r_in_range;

    // output register
    logic                                 r_ovld;
    ngate_pkg::t_out                      r_out;

    // per-channel valid bits: an unwritten entry reads as its reset value
    logic [ngate_pkg::CHANNELS-1:0]       r_vld;

    // state memory
    ngate_pkg::t_entry                    rd_entry;
    ngate_pkg::t_entry                    wr_entry;
    logic                                 mem_we;
    logic [ngate_pkg::CH_AW-1:0]          in_addr;
    logic [ngate_pkg::CH_AW-1:0]          cur_addr;

    // lookup decision
    logic                                 in_range;
    logic [ngate_pkg::PH_BITS-1:0]        cur_ph;
    logic [ngate_pkg::TIME_BITS-1:0]      cur_start;
    logic [ngate_pkg::TIME_BITS-1:0]      elapsed;
    logic                                 above;
    logic [ngate_pkg::PH_BITS-1:0]        new_ph;
    logic [ngate_pkg::TIME_BITS-1:0]      new_start;
    logic                                 out_zero;
    logic                                 need_div;
    logic                                 use_rel;
    logic                                 in_neg;
    logic [SB-1:0]                        in_mag;

    // divider
    logic                                 div_start;
    logic                                 div_done;
    logic [GB-1:0]                        div_quot;
    logic [GB:0]                          gain;

    // rescale
    logic [SB-1:0]                        scaled;
    logic                                 out_free;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_ovld;
    assign o_out       = r_out;
    assign out_free    = !r_ovld || i_out_ready;

    // ---------------------------------------------------------------
    // configuration
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr  <= '0;
            r_att  <= '0;
            r_hold <= '0;
            r_rel  <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                ngate_pkg::REG_THRESHOLD: r_thr  <= i_cfg_data[SB-1:0];
                ngate_pkg::REG_ATTACK:    r_att  <= i_cfg_data;
                ngate_pkg::REG_HOLD:      r_hold <= i_cfg_data;
                ngate_pkg::REG_RELEASE:   r_rel  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // channel state memory; read issued with the input transfer
    // ---------------------------------------------------------------
    assign in_addr  = i_in.chan[ngate_pkg::CH_AW-1:0];
    assign cur_addr = r_in.chan[ngate_pkg::CH_AW-1:0];
    assign wr_entry = '{phase: r_ph, start: r_start};
    assign mem_we   = (r_state == S_OUT) && out_free && r_in_range;

    ngate_ram #(
        .WIDTH (ngate_pkg::ENTRY_BITS),
        .DEPTH (ngate_pkg::CHANNELS)
    ) u_state_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (cur_addr),
        .i_wdata (wr_entry),
        .i_raddr (in_addr),
        .o_rdata (rd_entry)
    );

    // write-back lands before the next read can be issued, so no forwarding
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (mem_we) begin
            r_vld[cur_addr] <= 1'b1;
        end
    end

    // ---------------------------------------------------------------
    // phase decision, valid in the lookup cycle
    // ---------------------------------------------------------------
    assign in_range  = {1'b0, r_in.chan} < ngate_pkg::CH_COUNT;
    assign cur_ph    = r_vld[cur_addr] ? rd_entry.phase : ngate_pkg::PH_OPEN;
    assign cur_start = r_vld[cur_addr] ? rd_entry.start : '0;
    // time differences wrap modulo 2^32
    assign elapsed   = r_in.frame_time - cur_start;
    assign above     = r_in.in_sample >= r_thr;
    assign in_neg    = r_in.in_sample[SB-1];
    assign in_mag    = in_neg ? (~r_in.in_sample + SB'(1)) : r_in.in_sample;

    always_comb begin
        new_ph    = cur_ph;
        new_start = cur_start;
        out_zero  = 1'b0;
        need_div  = 1'b0;
        use_rel   = 1'b0;
        unique case (cur_ph)
            ngate_pkg::PH_CLOSED: begin
                out_zero = 1'b1;
                if (above) begin
                    new_ph    = ngate_pkg::PH_ATTACK;
                    new_start = r_in.frame_time;
                end
            end
            ngate_pkg::PH_ATTACK: begin
                // a zero attack time is always complete
                if (elapsed >= {8'd0, r_att}) begin
                    new_ph = ngate_pkg::PH_OPEN;
                end else begin
                    need_div = 1'b1;
                end
            end
            ngate_pkg::PH_OPEN: begin
                if (!above) begin
                    new_ph    = ngate_pkg::PH_HOLD;
                    new_start = r_in.frame_time;
                end
            end
            ngate_pkg::PH_HOLD: begin
                if (above) begin
                    new_ph = ngate_pkg::PH_OPEN;
                end else if (elapsed >= {8'd0, r_hold}) begin
                    new_ph    = ngate_pkg::PH_RELEASE;
                    new_start = r_in.frame_time;
                end
            end
            ngate_pkg::PH_RELEASE: begin
                if (above) begin
                    new_ph = ngate_pkg::PH_OPEN;
                end else if (elapsed >= {8'd0, r_rel}) begin
                    new_ph   = ngate_pkg::PH_CLOSED;
                    out_zero = 1'b1;
                end else begin
                    need_div = 1'b1;
                    use_rel  = 1'b1;
                end
            end
            default: begin
                new_ph = ngate_pkg::PH_OPEN;
            end
        endcase
        // channels beyond the count pass through untouched
        if (!in_range) begin
            new_ph   = ngate_pkg::PH_OPEN;
            out_zero = 1'b0;
            need_div = 1'b0;
        end
    end

    // ---------------------------------------------------------------
    // ramp gain: elapsed is below the ramp length whenever it is used
    // ---------------------------------------------------------------
    assign div_start = (r_state == S_LOOK) && need_div;

    ngate_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (elapsed[ngate_pkg::LEN_BITS-1:0]),
        .i_den   (use_rel ? r_rel : r_att),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    // release gain counts down from one
    assign gain   = r_rel_ramp ? (ngate_pkg::GAIN_ONE - {1'b0, div_quot})
                               : {1'b0, div_quot};
    // truncation toward zero: scale the magnitude, then restore the sign
    assign scaled = r_prod[GB +: SB];

    // ---------------------------------------------------------------
    // sequencer
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ovld  <= 1'b0;
        end else begin
            // a new result replaces the one leaving in the same cycle
            if ((r_state == S_OUT) && out_free) begin
                r_ovld <= 1'b1;
            end else if (i_out_ready) begin
                r_ovld <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= S_LOOK;
                    end
                end
                S_LOOK: begin
                    r_state <= need_div ? S_DIV : S_OUT;
                end
                S_DIV: begin
                    if (div_done) begin
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    // wait here while the previous result is still held
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in;
        end
        if (r_state == S_LOOK) begin
            r_in_range <= in_range;
            r_ph       <= new_ph;
            r_start    <= new_start;
            r_rel_ramp <= use_rel;
            r_neg      <= in_neg;
            r_mag      <= in_mag;
            r_y        <= out_zero ? '0 : r_in.in_sample;
        end
        if ((r_state == S_DIV) && div_done) begin
            r_prod <= PB'(r_mag) * PB'(gain);
        end
        if (r_state == S_MUL) begin
            r_y <= r_neg ? (~scaled + SB'(1)) : scaled;
        end
        if ((r_state == S_OUT) && out_free) begin
            r_out.out_chan   <= r_in.chan;
            r_out.out_sample <= r_y;
            r_out.gate_phase <= r_ph;
        end
    end

endmodule

`default_nettype wire

>>> src/ngate_chk.sv
// port-level checks for the noise gate, bound to the top level
// depends on ngate_pkg and noise_gate_attack_hold_release
`default_nettype none

module ngate_chk (
    input wire logic            i_clk,
    input wire logic            i_rst_n,
    input wire logic            i_in_valid,
    input wire logic            o_in_ready,
    input wire logic            o_out_valid,
    input wire logic            i_out_ready,
    input wire ngate_pkg::t_out o_out
);

    // a pending result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("output valid dropped before transfer");

    // a pending result keeps its payload
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_out))
        else $error("output payload changed while stalled");

    // one item at a time: the input closes after a transfer
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input taken while an item is in flight");

    // a closed gate outputs silence
    a_closed_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out.gate_phase == ngate_pkg::PH_CLOSED)
            |-> (o_out.out_sample == '0))
        else $error("closed gate passed a nonzero sample");

endmodule

bind noise_gate_attack_hold_release ngate_chk u_ngate_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out       (o_out)
);

`default_nettype wire
